>>> rtl/core/paep_pkg.sv
package paep_pkg;

  // degree memory word and saturation limit
  localparam int DEG_W = 16;
  localparam logic [DEG_W-1:0] DEG_MAX = 16'hFFFF;

  // running sum of degrees kept modulo 2^24
  localparam int SUM24_W = 24;

  // random fraction, product and threshold widths
  localparam int RAND_W = 32;
  localparam int PROD_W = RAND_W + SUM24_W;
  localparam int THR_W = SUM24_W + 1;

  // result node fields
  localparam int NODE_FIELD_W = 10;

  // configuration port
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_NODES_W = 11;
  localparam int CFG_LINKS_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINKS_PER_NODE = 1'b1;

  // operation codes
  localparam logic OP_RESTART = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  // sequencer states
  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_MUL,
    ST_THR,
    ST_SCAN,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_NEW,
    ST_EMIT
  } paep_state_t;

  // control from the sequencer to the roulette scan unit
  typedef struct packed {
    logic start;
    logic load_thr;
    logic take;
    logic skip;
  } scan_ctl_t;

endpackage

>>> rtl/core/paep_ram.sv
module paep_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/paep_scan.sv
module paep_scan #(
  parameter int NODE_W = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  input  paep_pkg::scan_ctl_t                 ctl,
  input  logic [paep_pkg::RAND_W-1:0]         random_value,
  input  logic [paep_pkg::SUM24_W-1:0]        sel_sum,
  input  logic [paep_pkg::DEG_W-1:0]          deg,
  input  logic [NODE_W-1:0]                   deg_idx,
  output logic                                hit,
  output logic [NODE_W-1:0]                   hit_idx,
  output logic [paep_pkg::DEG_W-1:0]          hit_deg
);

  localparam int SUM_W = NODE_W + paep_pkg::DEG_W;
  localparam int THR_W = paep_pkg::THR_W;
  localparam int CMP_W = (SUM_W > THR_W) ? SUM_W : THR_W;
  localparam int PROD_W = paep_pkg::PROD_W;
  localparam int RAND_W = paep_pkg::RAND_W;

  logic [PROD_W-1:0] prod;
  logic [THR_W-1:0]  thr;
  logic [SUM_W-1:0]  acc;
  logic [SUM_W-1:0]  acc_next;
  logic              reach;

  // r * S once per draw
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      prod <= PROD_W'(random_value) * PROD_W'(sel_sum);
    end
  end

  // threshold is ceil(r * S / 2^32)
  always_ff @(posedge clk) begin
    if (ctl.load_thr) begin
      thr <= {1'b0, prod[PROD_W-1:RAND_W]} + THR_W'(|prod[RAND_W-1:0]);
    end
  end

  // running cumulative degree and compare
  always_comb begin
    acc_next = acc + SUM_W'(deg);
    reach = CMP_W'(acc_next) >= CMP_W'(thr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
      acc <= '0;
    end else if (ctl.start) begin
      hit <= 1'b0;
      acc <= '0;
    end else if (ctl.take && !ctl.skip && !hit) begin
      acc <= acc_next;
      if (reach) begin
        hit <= 1'b1;
      end
    end
  end

  // picked node and its degree
  always_ff @(posedge clk) begin
    if (ctl.take && !ctl.skip && !hit && reach) begin
      hit_idx <= deg_idx;
      hit_deg <= deg;
    end
  end

endmodule

>>> rtl/core/preferential_attachment_edge_picker_top.sv
// draw: set-up in ST_MUL (r * S) and ST_THR (threshold), then one degree-memory read
//   per active node until the pick, then the result word once the output slot is free
// a node's final draw adds a degree read and write per pick, then seeds the new node
// restart: seed degrees written one per cycle, for nodes 0 to links_per_node
// one item in flight at a time; the single degree-memory read port sets the scan pace
// reset: control cleared, then seed writes before ready
module preferential_attachment_edge_picker_top #(
  parameter int MAX_NODES = 1024,
  parameter int MAX_LINKS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 operation,
  input  logic [paep_pkg::RAND_W-1:0]          random_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 edge_valid,
  output logic [paep_pkg::NODE_FIELD_W-1:0]    new_node,
  output logic [paep_pkg::NODE_FIELD_W-1:0]    target_node,
  output logic                                 last_of_node,
  output logic                                 network_done,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [paep_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [paep_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int AC_MAX = (MAX_NODES > MAX_LINKS + 1) ? MAX_NODES : MAX_LINKS + 1;
  localparam int AC_W = $clog2(AC_MAX + 1);
  localparam int LK_W = $clog2(MAX_LINKS + 1);
  localparam int PEND_W = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
  localparam int DEG_W = paep_pkg::DEG_W;
  localparam int S_W = paep_pkg::SUM24_W;
  localparam int FW = paep_pkg::NODE_FIELD_W;
  localparam int CN_W = paep_pkg::CFG_NODES_W;
  localparam int CL_W = paep_pkg::CFG_LINKS_W;
  localparam int RST_CFG_NODES = 1024;
  localparam int RST_CFG_LINKS = 2;
  localparam int RST_NODES = (RST_CFG_NODES > MAX_NODES) ? MAX_NODES : RST_CFG_NODES;
  localparam int RST_LINKS = (RST_CFG_LINKS > MAX_LINKS) ? MAX_LINKS : RST_CFG_LINKS;

  paep_pkg::paep_state_t state, state_next;
  paep_pkg::scan_ctl_t   ctl;

  logic [CN_W-1:0]   cfg_nodes;
  logic [CL_W-1:0]   cfg_links;
  logic [AC_W-1:0]   run_nodes;
  logic [LK_W-1:0]   run_links;
  logic [AC_W-1:0]   active_count;
  logic [LK_W-1:0]   draw_index;
  logic [NODE_W-1:0] pending [MAX_LINKS];
  logic [S_W-1:0]    unchosen_sum;
  logic [S_W-1:0]    total_sum;
  logic [S_W-1:0]    sel_sum;
  logic [paep_pkg::RAND_W-1:0] rand_q;
  logic [AC_W-1:0]   rd_idx;
  logic              rd_vld;
  logic [NODE_W-1:0] rd_idx_d;
  logic [LK_W-1:0]   upd_j;
  logic [NODE_W-1:0] init_idx;
  logic              init_emit;
  logic              init_last;
  logic              res_edge;
  logic [FW-1:0]     res_new;
  logic [FW-1:0]     res_target;
  logic              res_last;
  logic              res_nofind;

  logic              accept;
  logic              slot_free;
  logic              build_done;
  logic              issue;
  logic              scan_end;
  logic              draw_complete;
  logic              upd_last;
  logic [31:0]       nodes_sat;
  logic [31:0]       links_sat;
  logic [NODE_W-1:0] upd_addr;
  logic [DEG_W-1:0]  deg_inc;
  logic              inc_ok;
  logic              chosen_rd;
  logic              chosen_hit;

  logic              ram_we;
  logic [NODE_W-1:0] ram_waddr;
  logic [DEG_W-1:0]  ram_wdata;
  logic [NODE_W-1:0] ram_raddr;
  logic [DEG_W-1:0]  ram_rdata;

  logic              hit;
  logic [NODE_W-1:0] hit_idx;
  logic [DEG_W-1:0]  hit_deg;

  // handshake and status terms
  assign in_ready = (state == paep_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;
  assign build_done = (32'(active_count) >= 32'(run_nodes)) ||
                      (32'(active_count) >= 32'(MAX_NODES));
  assign sel_sum = (draw_index == '0) ? total_sum : unchosen_sum;
  assign issue = (state == paep_pkg::ST_SCAN) && (rd_idx < active_count);
  assign scan_end = !hit && !rd_vld && (rd_idx >= active_count);
  assign draw_complete = ({1'b0, draw_index} + 1'b1) >= {1'b0, run_links};
  assign upd_last = ({1'b0, upd_j} + 1'b1) >= {1'b0, run_links};
  assign init_last = (32'(init_idx) == 32'(run_links)) || (init_idx == '1);
  assign upd_addr = pending[upd_j[PEND_W-1:0]];
  assign inc_ok = (ram_rdata != paep_pkg::DEG_MAX);
  assign deg_inc = inc_ok ? ram_rdata + 1'b1 : ram_rdata;

  // configuration registers saturated into run values at restart
  always_comb begin
    nodes_sat = 32'(cfg_nodes);
    if (nodes_sat > 32'(MAX_NODES)) begin
      nodes_sat = 32'(MAX_NODES);
    end else if (nodes_sat < 32'd2) begin
      nodes_sat = 32'd2;
    end
    links_sat = 32'(cfg_links);
    if (links_sat > 32'(MAX_LINKS)) begin
      links_sat = 32'(MAX_LINKS);
    end else if (links_sat < 32'd1) begin
      links_sat = 32'd1;
    end
  end

  // nodes already picked for the current new node
  always_comb begin
    chosen_rd = 1'b0;
    chosen_hit = 1'b0;
    for (int j = 0; j < MAX_LINKS; j++) begin
      if (32'(j) < 32'(draw_index)) begin
        if (pending[j] == rd_idx_d) begin
          chosen_rd = 1'b1;
        end
        if (pending[j] == hit_idx) begin
          chosen_hit = 1'b1;
        end
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      paep_pkg::ST_INIT: begin
        if (init_last) begin
          state_next = init_emit ? paep_pkg::ST_EMIT : paep_pkg::ST_IDLE;
        end
      end
      paep_pkg::ST_IDLE: begin
        if (accept) begin
          if (operation == paep_pkg::OP_RESTART) begin
            state_next = paep_pkg::ST_INIT;
          end else if (build_done) begin
            state_next = paep_pkg::ST_EMIT;
          end else begin
            state_next = paep_pkg::ST_MUL;
          end
        end
      end
      paep_pkg::ST_MUL: state_next = paep_pkg::ST_THR;
      paep_pkg::ST_THR: state_next = paep_pkg::ST_SCAN;
      paep_pkg::ST_SCAN: begin
        if (hit) begin
          state_next = draw_complete ? paep_pkg::ST_UPD_RD : paep_pkg::ST_EMIT;
        end else if (scan_end) begin
          state_next = paep_pkg::ST_EMIT;
        end
      end
      paep_pkg::ST_UPD_RD: state_next = paep_pkg::ST_UPD_WR;
      paep_pkg::ST_UPD_WR: begin
        state_next = upd_last ? paep_pkg::ST_NEW : paep_pkg::ST_UPD_RD;
      end
      paep_pkg::ST_NEW: state_next = paep_pkg::ST_EMIT;
      paep_pkg::ST_EMIT: begin
        if (slot_free) begin
          state_next = paep_pkg::ST_IDLE;
        end
      end
      default: state_next = paep_pkg::ST_IDLE;
    endcase
  end

  // memory port and scan unit control
  always_comb begin
    ram_we = 1'b0;
    ram_waddr = init_idx;
    ram_wdata = DEG_W'(run_links);
    ram_raddr = rd_idx[NODE_W-1:0];
    ctl = '0;
    ctl.take = rd_vld;
    ctl.skip = chosen_rd;
    case (state)
      paep_pkg::ST_INIT: begin
        ram_we = 1'b1;
      end
      paep_pkg::ST_MUL: begin
        ctl.start = 1'b1;
      end
      paep_pkg::ST_THR: begin
        ctl.load_thr = 1'b1;
      end
      paep_pkg::ST_UPD_RD: begin
        ram_raddr = upd_addr;
      end
      paep_pkg::ST_UPD_WR: begin
        ram_we = 1'b1;
        ram_waddr = upd_addr;
        ram_wdata = deg_inc;
      end
      paep_pkg::ST_NEW: begin
        ram_we = 1'b1;
        ram_waddr = active_count[NODE_W-1:0];
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= paep_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_nodes <= CN_W'(RST_CFG_NODES);
      cfg_links <= CL_W'(RST_CFG_LINKS);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        paep_pkg::CFG_NODE_COUNT: cfg_nodes <= cfg_data[CN_W-1:0];
        paep_pkg::CFG_LINKS_PER_NODE: cfg_links <= cfg_data[CL_W-1:0];
        default: cfg_nodes <= cfg_nodes;
      endcase
    end
  end

  // build state: run values, node count, draw position, degree sums
  always_ff @(posedge clk) begin
    if (rst) begin
      run_nodes <= AC_W'(RST_NODES);
      run_links <= LK_W'(RST_LINKS);
      active_count <= AC_W'(RST_LINKS + 1);
      draw_index <= '0;
      total_sum <= S_W'(RST_LINKS * (RST_LINKS + 1));
      init_idx <= '0;
      init_emit <= 1'b0;
      upd_j <= '0;
    end else begin
      case (state)
        paep_pkg::ST_INIT: begin
          init_idx <= init_idx + 1'b1;
        end
        paep_pkg::ST_IDLE: begin
          if (accept && operation == paep_pkg::OP_RESTART) begin
            run_nodes <= AC_W'(nodes_sat);
            run_links <= LK_W'(links_sat);
            active_count <= AC_W'(links_sat + 32'd1);
            draw_index <= '0;
            total_sum <= S_W'(links_sat * (links_sat + 32'd1));
            init_idx <= '0;
            init_emit <= 1'b1;
          end
        end
        paep_pkg::ST_SCAN: begin
          if (hit) begin
            upd_j <= '0;
            if (!draw_complete) begin
              draw_index <= draw_index + 1'b1;
            end
          end
        end
        paep_pkg::ST_UPD_WR: begin
          upd_j <= upd_j + 1'b1;
          total_sum <= total_sum + S_W'(inc_ok);
        end
        paep_pkg::ST_NEW: begin
          total_sum <= total_sum + S_W'(run_links);
          active_count <= active_count + 1'b1;
          draw_index <= '0;
        end
        default: begin
          init_emit <= init_emit;
        end
      endcase
    end
  end

  // payload held for the duration of an item
  always_ff @(posedge clk) begin
    if (accept) begin
      rand_q <= random_value;
      res_edge <= 1'b0;
      res_new <= '0;
      res_target <= '0;
      res_last <= 1'b0;
      res_nofind <= 1'b0;
    end
    if (state == paep_pkg::ST_SCAN) begin
      if (hit) begin
        pending[draw_index[PEND_W-1:0]] <= hit_idx;
        unchosen_sum <= sel_sum - S_W'(hit_deg);
        res_edge <= 1'b1;
        res_new <= FW'(active_count);
        res_target <= FW'(hit_idx);
        res_last <= draw_complete;
      end else if (scan_end) begin
        res_nofind <= 1'b1;
      end
    end
  end

  // scan read pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
      rd_idx <= '0;
    end else begin
      rd_vld <= issue;
      if (state == paep_pkg::ST_THR) begin
        rd_idx <= '0;
      end else if (issue) begin
        rd_idx <= rd_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_d <= rd_idx[NODE_W-1:0];
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == paep_pkg::ST_EMIT && slot_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == paep_pkg::ST_EMIT && slot_free) begin
      edge_valid <= res_edge;
      new_node <= res_new;
      target_node <= res_target;
      last_of_node <= res_last;
      network_done <= !res_nofind && (32'(active_count) >= 32'(run_nodes));
    end
  end

  paep_ram #(
    .WIDTH(DEG_W),
    .DEPTH(MAX_NODES)
  ) u_deg_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  paep_scan #(
    .NODE_W(NODE_W)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .random_value(rand_q),
    .sel_sum     (sel_sum),
    .deg         (ram_rdata),
    .deg_idx     (rd_idx_d),
    .hit         (hit),
    .hit_idx     (hit_idx),
    .hit_deg     (hit_deg)
  );

  // draw position stays below the link count of the run
  a_draw_index: assert property (@(posedge clk) disable iff (rst)
    draw_index < run_links)
    else $error("draw position beyond link count");

  // link count of the run stays within its saturated range
  a_links_range: assert property (@(posedge clk) disable iff (rst)
    (32'(run_links) >= 32'd1) && (32'(run_links) <= 32'(MAX_LINKS)))
    else $error("link count out of range");

  // a pick is always an active node
  a_hit_active: assert property (@(posedge clk) disable iff (rst)
    (state == paep_pkg::ST_SCAN && hit) |-> (32'(hit_idx) < 32'(active_count)))
    else $error("picked node not active");

  // a pick is never a node already taken for this new node
  a_hit_unchosen: assert property (@(posedge clk) disable iff (rst)
    (state == paep_pkg::ST_SCAN && hit) |-> !chosen_hit)
    else $error("node picked twice for one new node");

endmodule

>>> verif/tb_preferential_attachment_edge_picker_top.sv
module tb_preferential_attachment_edge_picker_top;

  localparam int MAX_NODES = 1024;
  localparam int MAX_LINKS = 8;
  localparam int TOTAL_ITEMS = 580;
  // slowest word: a full scan of up to 1023 active nodes plus set-up and degree updates,
  // plus receiver stalls; taken several times over
  localparam int STALL_LIMIT = 8000;
  localparam int SEQ_DRAWS_MAX = 60;

  // one result word as seen on the output port
  typedef struct packed {
    logic                              edge_valid;
    logic [paep_pkg::NODE_FIELD_W-1:0] new_node;
    logic [paep_pkg::NODE_FIELD_W-1:0] target_node;
    logic                              last_of_node;
    logic                              network_done;
  } edge_word_t;

  // graph-building predictor and store of predicted edge words
  class attach_scoreboard;
    edge_word_t  predicted_edges[$];
    int unsigned errors;
    bit [15:0]   degree[MAX_NODES];
    bit          chosen[MAX_NODES];
    int unsigned picks[MAX_LINKS];
    int unsigned active;
    int unsigned draws;
    bit [23:0]   unchosen;
    bit [10:0]   cfg_nodes;
    bit [3:0]    cfg_links;
    int unsigned run_nodes;
    int unsigned run_links;

    function new();
      errors = 0;
      cfg_nodes = 11'd1024;
      cfg_links = 4'd2;
      seed_clique();
    endfunction

    // latch the registers and seed a clique of links+1 nodes
    function void seed_clique();
      int unsigned n;
      int unsigned k;
      n = cfg_nodes;
      k = cfg_links;
      if (n > MAX_NODES) n = MAX_NODES;
      if (n < 2) n = 2;
      if (k > MAX_LINKS) k = MAX_LINKS;
      if (k < 1) k = 1;
      run_nodes = n;
      run_links = k;
      for (int i = 0; i < MAX_NODES; i++) begin
        degree[i] = 16'(k);
        chosen[i] = 1'b0;
      end
      active = k + 1;
      draws = 0;
      unchosen = 24'((k + 1) * k);
    endfunction

    function void note_config(logic [paep_pkg::CFG_IDX_W-1:0] idx,
                              logic [paep_pkg::CFG_DATA_W-1:0] data);
      if (idx == paep_pkg::CFG_NODE_COUNT) cfg_nodes = data;
      else cfg_links = data[3:0];
    endfunction

    // roulette pick over unchosen active nodes, then degree update on completion
    function void note_item(logic op, logic [paep_pkg::RAND_W-1:0] r);
      edge_word_t  w;
      bit [63:0]   c;
      bit [63:0]   lhs;
      int unsigned sum;
      int unsigned pick;
      int unsigned nn;
      bit          found;
      w = '0;
      c = 0;
      pick = 0;
      found = 1'b0;
      if (op == paep_pkg::OP_RESTART) begin
        seed_clique();
        w.network_done = (active >= run_nodes);
      end else if (active >= run_nodes || active >= MAX_NODES) begin
        w.network_done = 1'b1;
      end else begin
        // sum of degrees loaded at the first draw of each new node
        if (draws == 0) begin
          sum = 0;
          for (int i = 0; i < active; i++) sum += 32'(degree[i]);
          unchosen = sum[23:0];
        end
        lhs = 64'(r) * 64'(unchosen);
        for (int i = 0; i < active && !found; i++) begin
          if (!chosen[i]) begin
            c += 64'(degree[i]);
            if (lhs <= (c << 32)) begin
              pick = i;
              found = 1'b1;
            end
          end
        end
        if (found && draws < MAX_LINKS) begin
          nn = active;
          chosen[pick] = 1'b1;
          picks[draws] = pick;
          unchosen = unchosen - 24'(degree[pick]);
          draws++;
          w.edge_valid = 1'b1;
          w.new_node = paep_pkg::NODE_FIELD_W'(nn);
          w.target_node = paep_pkg::NODE_FIELD_W'(pick);
          if (draws >= run_links) begin
            // node complete: chosen degrees rise, saturating
            for (int i = 0; i < draws; i++) begin
              if (degree[picks[i]] != 16'hFFFF) degree[picks[i]]++;
              chosen[picks[i]] = 1'b0;
            end
            degree[nn] = 16'(run_links);
            active++;
            draws = 0;
            w.last_of_node = 1'b1;
          end
          w.network_done = (active >= run_nodes);
        end
      end
      predicted_edges = {predicted_edges, w};
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        if (errors <= 10)
          $display("mismatch on %s: expected %0d, got %0d", name, want, got);
      end
    endfunction

    function void check_result(edge_word_t got);
      edge_word_t want;
      if (predicted_edges.size() == 0) begin
        errors++;
        if (errors <= 10) $display("edge word with none predicted: %p", got);
      end else begin
        want = predicted_edges.pop_front();
        compare_field("edge_valid", want.edge_valid, got.edge_valid);
        compare_field("new_node", want.new_node, got.new_node);
        compare_field("target_node", want.target_node, got.target_node);
        compare_field("last_of_node", want.last_of_node, got.last_of_node);
        compare_field("network_done", want.network_done, got.network_done);
      end
    endfunction

    function int pending();
      return predicted_edges.size();
    endfunction
  endclass

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic                              operation = paep_pkg::OP_RESTART;
  logic [paep_pkg::RAND_W-1:0]       random_value = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic                              edge_valid;
  logic [paep_pkg::NODE_FIELD_W-1:0] new_node;
  logic [paep_pkg::NODE_FIELD_W-1:0] target_node;
  logic                              last_of_node;
  logic                              network_done;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [paep_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
  logic [paep_pkg::CFG_DATA_W-1:0]   cfg_data = '0;

  attach_scoreboard sb;
  int send_idle_pct = 26;
  int recv_idle_pct = 80;
  int items_sent = 0;
  int stall_cycles = 0;

  preferential_attachment_edge_picker_top #(
    .MAX_NODES(MAX_NODES),
    .MAX_LINKS(MAX_LINKS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operation(operation),
    .random_value(random_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .edge_valid(edge_valid),
    .new_node(new_node),
    .target_node(target_node),
    .last_of_node(last_of_node),
    .network_done(network_done),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // result word check
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result({edge_valid, new_node, target_node, last_of_node, network_done});
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  function automatic logic [paep_pkg::RAND_W-1:0] rand_fraction();
    int sel;
    sel = $urandom_range(99);
    if (sel < 10) return '0;
    else if (sel < 20) return '1;
    else return $urandom;
  endfunction

  // offer one input word, valid held until taken
  task automatic send_item(input logic op, input logic [paep_pkg::RAND_W-1:0] r);
    int gap;
    if (items_sent < TOTAL_ITEMS / 3) begin
      send_idle_pct = 26;
      recv_idle_pct = 80;
    end else if (items_sent < 2 * TOTAL_ITEMS / 3) begin
      send_idle_pct = 80;
      recv_idle_pct = 26;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    random_value <= r;
    do @(posedge clk); while (!in_ready);
    sb.note_item(op, r);
    items_sent++;
  endtask

  // drain: no input offered until every predicted word has come back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [paep_pkg::CFG_IDX_W-1:0] idx,
                           input logic [paep_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.note_config(idx, data);
  endtask

  task automatic write_config(input logic [paep_pkg::CFG_DATA_W-1:0] nodes_word,
                              input logic [paep_pkg::CFG_DATA_W-1:0] links_word,
                              input logic [1:0] mask);
    if (mask[0]) write_reg(paep_pkg::CFG_NODE_COUNT, nodes_word);
    if (mask[1]) write_reg(paep_pkg::CFG_LINKS_PER_NODE, links_word);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int sel;
    int nodes_word;
    int links_word;
    int need;
    int draw_count;
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset settings: extremes of the fraction, then restart part-way through a node
    send_item(paep_pkg::OP_DRAW, '0);
    send_item(paep_pkg::OP_DRAW, '1);
    send_item(paep_pkg::OP_DRAW, 32'h8000_0000);
    send_item(paep_pkg::OP_RESTART, '1);

    // seed clique already covers the node count, then a draw after completion
    settle();
    write_config(11'd5, 11'd15, 2'b11);
    send_item(paep_pkg::OP_RESTART, '0);
    send_item(paep_pkg::OP_DRAW, $urandom);

    // both registers below range, saturating to the smallest build
    settle();
    write_config(11'd0, 11'h7F0, 2'b11);
    send_item(paep_pkg::OP_RESTART, $urandom);
    send_item(paep_pkg::OP_DRAW, '1);

    // complete small build followed by one extra draw
    settle();
    write_config(11'd6, 11'd2, 2'b11);
    send_item(paep_pkg::OP_RESTART, '0);
    for (int i = 0; i < 7; i++) send_item(paep_pkg::OP_DRAW, (i % 2) ? '1 : '0);

    // node count above range with the widest link count
    settle();
    write_config(11'h7FF, 11'd8, 2'b11);
    send_item(paep_pkg::OP_RESTART, '1);
    for (int i = 0; i < 3; i++) send_item(paep_pkg::OP_DRAW, $urandom);

    // random builds: mostly restart then enough draws to finish, with noise
    while (items_sent < TOTAL_ITEMS) begin
      sel = $urandom_range(99);
      if (sel < 70) nodes_word = $urandom_range(40, 2);
      else if (sel < 80) nodes_word = $urandom_range(120, 41);
      else if (sel < 88) nodes_word = $urandom_range(1024, 121);
      else if (sel < 94) nodes_word = $urandom_range(1, 0);
      else nodes_word = $urandom_range(2047, 1025);
      sel = $urandom_range(99);
      if (sel < 85) links_word = $urandom_range(8, 1);
      else if (sel < 92) links_word = 0;
      else links_word = $urandom_range(15, 9);
      links_word = links_word | ($urandom_range(127) << 4);
      settle();
      write_config(11'(nodes_word), 11'(links_word), 2'($urandom_range(3, 1)));
      if ($urandom_range(99) >= 10) send_item(paep_pkg::OP_RESTART, $urandom);
      if (sb.run_nodes > sb.active) need = (sb.run_nodes - sb.active) * sb.run_links;
      else need = 0;
      draw_count = need + $urandom_range(3, 0);
      if (draw_count > SEQ_DRAWS_MAX) draw_count = SEQ_DRAWS_MAX;
      if (draw_count > TOTAL_ITEMS - items_sent) draw_count = TOTAL_ITEMS - items_sent;
      for (int i = 0; i < draw_count; i++) begin
        if ($urandom_range(99) < 4) send_item(paep_pkg::OP_RESTART, rand_fraction());
        else send_item(paep_pkg::OP_DRAW, rand_fraction());
      end
    end

    settle();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
